// ===== hw/rtl/cssd_pkg.sv =====
// Shared types, constants and functions for the seven-segment clock and stopwatch.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cssd_pkg;

    localparam int MS_W      = 16;
    localparam int CMP_W     = (MS_W > 16) ? MS_W : 16;
    localparam int SEC_W     = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [MS_W-1:0] MS_MAX      = {MS_W{1'b1}};
    localparam logic [7:0]      REFRESH_MAX = 8'hFF;

    localparam logic [15:0] CLOCK_PERIOD_RST     = 16'd1000;
    localparam logic [15:0] STOPWATCH_PERIOD_RST = 16'd16;
    localparam logic [7:0]  REFRESH_PERIOD_RST   = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_PERIOD     = 2'd0,
        CFG_STOPWATCH_PERIOD = 2'd1,
        CFG_REFRESH_PERIOD   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_CLOCK = 3'b001,
        MODE_RUN   = 3'b010,
        MODE_PAUSE = 3'b100
    } t_mode;

    localparam logic [1:0] MODE_CODE_CLOCK = 2'd0;
    localparam logic [1:0] MODE_CODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_CODE_PAUSE = 2'd2;

    localparam logic [1:0] DIG_SEC_UNITS = 2'd0;
    localparam logic [1:0] DIG_SEC_TENS  = 2'd1;
    localparam logic [1:0] DIG_MIN_UNITS = 2'd2;
    localparam logic [1:0] DIG_MIN_TENS  = 2'd3;

    localparam logic [7:0] SEL_SEC_UNITS = 8'h7F;
    localparam logic [7:0] SEL_SEC_TENS  = 8'hBF;
    localparam logic [7:0] SEL_MIN_UNITS = 8'hDF;
    localparam logic [7:0] SEL_MIN_TENS  = 8'hEF;
    localparam logic [7:0] SEG_DP        = 8'h80;

    typedef struct packed {
        logic [2:0] m10;
        logic [3:0] m1;
        logic [2:0] s10;
        logic [3:0] s1;
    } t_time;

    typedef struct packed {
        logic tick;
        logic press_mode;
        logic press_pause;
        logic press_clear;
    } t_item;

    typedef struct packed {
        logic [15:0] clock_period;
        logic [15:0] sw_period;
        logic [7:0]  refresh_period;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       digit_drive;
        logic [7:0]       segment_drive;
        logic             refreshed;
        logic [1:0]       mode_now;
        logic [SEC_W-1:0] seconds_now;
    } t_result;

    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0: p = 8'h3F;
            4'd1: p = 8'h06;
            4'd2: p = 8'h5B;
            4'd3: p = 8'h4F;
            4'd4: p = 8'h66;
            4'd5: p = 8'h6D;
            4'd6: p = 8'h7D;
            4'd7: p = 8'h27;
            4'd8: p = 8'h7F;
            4'd9: p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] digit_sel(input logic [1:0] idx);
        logic [7:0] s;
        case (idx)
            DIG_SEC_UNITS: s = SEL_SEC_UNITS;
            DIG_SEC_TENS:  s = SEL_SEC_TENS;
            DIG_MIN_UNITS: s = SEL_MIN_UNITS;
            default:       s = SEL_MIN_TENS;
        endcase
        return s;
    endfunction

    // Advances mm:ss by one second, wrapping from 59:59 to 00:00.
    function automatic t_time time_inc(input t_time t);
        t_time r;
        r = t;
        if (t.s1 == 4'd9) begin
            r.s1 = 4'd0;
            if (t.s10 == 3'd5) begin
                r.s10 = 3'd0;
                if (t.m1 == 4'd9) begin
                    r.m1 = 4'd0;
                    if (t.m10 == 3'd5) begin
                        r.m10 = 3'd0;
                    end else begin
                        r.m10 = t.m10 + 3'd1;
                    end
                end else begin
                    r.m1 = t.m1 + 4'd1;
                end
            end else begin
                r.s10 = t.s10 + 3'd1;
            end
        end else begin
            r.s1 = t.s1 + 4'd1;
        end
        return r;
    endfunction

    function automatic logic [SEC_W-1:0] time_to_sec(input t_time t);
        logic [SEC_W-1:0] v;
        v = SEC_W'(t.m10) * SEC_W'(600) + SEC_W'(t.m1) * SEC_W'(60)
          + SEC_W'(t.s10) * SEC_W'(10) + SEC_W'(t.s1);
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cssd_in_stage.sv =====
// Input register stage that holds one accepted request until the core takes it.
// Depends on cssd_pkg for the request type.
`default_nettype none

module cssd_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  cssd_pkg::t_item     i_item,
    output logic                o_valid,
    output cssd_pkg::t_item     o_item,
    input  wire logic           i_take
);

    logic            r_valid;
    cssd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cssd_core.sv =====
// Button handling, millisecond and refresh counters, mm:ss time and digit multiplexing.
// Depends on cssd_pkg for types, fonts and time arithmetic.
`default_nettype none

module cssd_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  cssd_pkg::t_item     i_item,
    input  cssd_pkg::t_cfg      i_cfg,
    output cssd_pkg::t_result   o_result
);

    cssd_pkg::t_mode            r_mode, n_mode;
    cssd_pkg::t_time            r_time, n_time;
    cssd_pkg::t_time            r_saved, n_saved;
    logic [cssd_pkg::MS_W-1:0]  r_ms, n_ms;
    logic [7:0]                 r_refresh, n_refresh;
    logic                       r_mode_tgl, n_mode_tgl;
    logic                       r_pause_tgl, n_pause_tgl;
    logic                       r_clear_armed, n_clear_armed;
    logic                       r_restart, n_restart;
    logic [1:0]                 r_digit_idx, n_digit_idx;
    logic [7:0]                 r_digit, n_digit;
    logic [7:0]                 r_segment, n_segment;
    logic                       refresh_hit;
    logic [15:0]                period;
    logic [7:0]                 pattern;
    logic [1:0]                 mode_code;

    always_comb begin
        n_mode        = r_mode;
        n_time        = r_time;
        n_saved       = r_saved;
        n_ms          = r_ms;
        n_refresh     = r_refresh;
        n_mode_tgl    = r_mode_tgl;
        n_pause_tgl   = r_pause_tgl;
        n_clear_armed = r_clear_armed;
        n_restart     = r_restart;
        n_digit_idx   = r_digit_idx;
        n_digit       = r_digit;
        n_segment     = r_segment;

        if (i_item.press_mode) begin
            n_mode_tgl = !r_mode_tgl;
            if (n_mode_tgl) begin
                n_saved = r_time;
                n_time  = '0;
                n_mode  = cssd_pkg::MODE_RUN;
            end else begin
                n_time = r_saved;
                n_mode = cssd_pkg::MODE_CLOCK;
            end
        end

        if (i_item.press_pause) begin
            n_pause_tgl = !r_pause_tgl;
            if (n_pause_tgl) begin
                n_mode        = cssd_pkg::MODE_PAUSE;
                n_clear_armed = 1'b1;
            end
            if (!n_pause_tgl || r_restart) begin
                n_mode        = cssd_pkg::MODE_RUN;
                n_clear_armed = 1'b0;
                n_restart     = 1'b0;
            end
        end

        if (i_item.press_clear && n_clear_armed) begin
            n_time    = '0;
            n_restart = 1'b1;
        end

        if (i_item.tick) begin
            if (r_ms != cssd_pkg::MS_MAX) begin
                n_ms = r_ms + cssd_pkg::MS_W'(1);
            end
            if (r_refresh != cssd_pkg::REFRESH_MAX) begin
                n_refresh = r_refresh + 8'd1;
            end
        end

        case (r_digit_idx)
            cssd_pkg::DIG_SEC_UNITS: pattern = cssd_pkg::seg_font(n_time.s1);
            cssd_pkg::DIG_SEC_TENS:  pattern = cssd_pkg::seg_font({1'b0, n_time.s10});
            cssd_pkg::DIG_MIN_UNITS: begin
                pattern = cssd_pkg::seg_font(n_time.m1)
                        | (n_time.s1[0] ? cssd_pkg::SEG_DP : 8'h00);
            end
            default: pattern = cssd_pkg::seg_font({1'b0, n_time.m10});
        endcase

        refresh_hit = (n_refresh >= i_cfg.refresh_period);
        if (refresh_hit) begin
            n_refresh   = 8'd0;
            n_digit     = cssd_pkg::digit_sel(r_digit_idx);
            n_segment   = pattern;
            n_digit_idx = r_digit_idx + 2'd1;
        end

        period = (n_mode == cssd_pkg::MODE_CLOCK) ? i_cfg.clock_period : i_cfg.sw_period;
        if ((n_mode == cssd_pkg::MODE_CLOCK || n_mode == cssd_pkg::MODE_RUN)
                && (cssd_pkg::CMP_W'(n_ms) >= cssd_pkg::CMP_W'(period))) begin
            n_ms   = '0;
            n_time = cssd_pkg::time_inc(n_time);
        end

        case (n_mode)
            cssd_pkg::MODE_CLOCK: mode_code = cssd_pkg::MODE_CODE_CLOCK;
            cssd_pkg::MODE_RUN:   mode_code = cssd_pkg::MODE_CODE_RUN;
            default:              mode_code = cssd_pkg::MODE_CODE_PAUSE;
        endcase

        o_result.digit_drive   = n_digit;
        o_result.segment_drive = n_segment;
        o_result.refreshed     = refresh_hit;
        o_result.mode_now      = mode_code;
        o_result.seconds_now   = cssd_pkg::time_to_sec(n_time);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cssd_pkg::MODE_CLOCK;
            r_time        <= '0;
            r_saved       <= '0;
            r_ms          <= '0;
            r_refresh     <= 8'd0;
            r_mode_tgl    <= 1'b0;
            r_pause_tgl   <= 1'b0;
            r_clear_armed <= 1'b0;
            r_restart     <= 1'b0;
            r_digit_idx   <= 2'd0;
            r_digit       <= 8'd0;
            r_segment     <= 8'd0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_time        <= n_time;
            r_saved       <= n_saved;
            r_ms          <= n_ms;
            r_refresh     <= n_refresh;
            r_mode_tgl    <= n_mode_tgl;
            r_pause_tgl   <= n_pause_tgl;
            r_clear_armed <= n_clear_armed;
            r_restart     <= n_restart;
            r_digit_idx   <= n_digit_idx;
            r_digit       <= n_digit;
            r_segment     <= n_segment;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clock_stopwatch_seven_segment.sv =====
// A request waits in the input register; its result is held in the result register.
// Throughput: one request per cycle unless i_ready holds a result back; the input
// and result registers keep both sides moving; the core updates all state at once.
// Reset is synchronous and active low: it empties both registers, zeroes the time,
// counters and display, selects clock mode and loads the default periods.
`default_nettype none

module clock_stopwatch_seven_segment (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_tick,
    input  wire logic                           i_press_mode,
    input  wire logic                           i_press_pause,
    input  wire logic                           i_press_clear,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [7:0]                          o_digit_drive,
    output logic [7:0]                          o_segment_drive,
    output logic                                o_refreshed,
    output logic [1:0]                          o_mode_now,
    output logic [cssd_pkg::SEC_W-1:0]          o_seconds_now,
    input  wire logic                           i_cfg_we,
    input  wire logic [cssd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cssd_pkg::CFG_W-1:0]     i_cfg_data
);

    cssd_pkg::t_cfg    r_cfg;
    cssd_pkg::t_item   in_item;
    cssd_pkg::t_item   stage_item;
    cssd_pkg::t_result core_result;
    cssd_pkg::t_result r_out;
    logic              stage_valid;
    logic              s_fire;
    logic              r_out_valid;

    assign in_item.tick        = i_tick;
    assign in_item.press_mode  = i_press_mode;
    assign in_item.press_pause = i_press_pause;
    assign in_item.press_clear = i_press_clear;

    assign s_fire = stage_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_period   <= cssd_pkg::CLOCK_PERIOD_RST;
            r_cfg.sw_period      <= cssd_pkg::STOPWATCH_PERIOD_RST;
            r_cfg.refresh_period <= cssd_pkg::REFRESH_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (cssd_pkg::t_cfg_idx'(i_cfg_idx))
                cssd_pkg::CFG_CLOCK_PERIOD:     r_cfg.clock_period   <= i_cfg_data;
                cssd_pkg::CFG_STOPWATCH_PERIOD: r_cfg.sw_period      <= i_cfg_data;
                cssd_pkg::CFG_REFRESH_PERIOD:   r_cfg.refresh_period <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    cssd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (s_fire)
    );

    cssd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s_fire),
        .i_item   (stage_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out <= core_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_digit_drive   = r_out.digit_drive;
    assign o_segment_drive = r_out.segment_drive;
    assign o_refreshed     = r_out.refreshed;
    assign o_mode_now      = r_out.mode_now;
    assign o_seconds_now   = r_out.seconds_now;

`ifndef ASSERT_OFF
    a_seconds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seconds_now < 12'd3600))
        else $error("seconds count out of range");

    a_refresh_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_refreshed) |->
            (o_digit_drive == cssd_pkg::SEL_SEC_UNITS
             || o_digit_drive == cssd_pkg::SEL_SEC_TENS
             || o_digit_drive == cssd_pkg::SEL_MIN_UNITS
             || o_digit_drive == cssd_pkg::SEL_MIN_TENS))
        else $error("refresh without a valid digit select");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> o_valid)
        else $error("processed request produced no result");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stage_valid |-> o_ready)
        else $error("input refused while the input register is empty");
`endif

endmodule

`default_nettype wire
